@@ rtl/core/nrzdh_pkg.sv @@
package nrzdh_pkg;

  localparam int FRAME_SYMBOLS  = 120;
  localparam int OFFSET_SYMBOLS = 8;
  localparam int CODED_BLOCKS   = 14;
  localparam int SYMBOL_BITS    = 10;

  localparam int PAYLOAD_END = OFFSET_SYMBOLS + 8 * CODED_BLOCKS;
  localparam bit TOO_SHORT   = PAYLOAD_END > FRAME_SYMBOLS;

  localparam int IDX_W = $clog2(FRAME_SYMBOLS + 1);
  localparam logic [IDX_W-1:0] OFF_IDX  = IDX_W'(TOO_SHORT ? 0 : OFFSET_SYMBOLS);
  localparam logic [IDX_W-1:0] END_IDX  = IDX_W'(TOO_SHORT ? 0 : PAYLOAD_END);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_SYMBOLS - 1);
  localparam logic [3:0]       POS_LAST = 4'(SYMBOL_BITS - 1);
  localparam logic [3:0]       POS_MSB  = 4'd1;
  localparam logic [3:0]       POS_LSB  = 4'd8;

  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int BQ_DEPTH = 2;
  localparam int BQ_PTR_W = 1;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [3:0] SYN_PARITY_ONLY = 4'h8;
  localparam logic [3:0] SYN_FIRST_DATA  = 4'h9;

  typedef struct packed {
    logic            fresh;
    logic            has_block;
    logic            has_status;
    logic [7:0][7:0] syms;
  } blk_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       data;
    logic             ok;
    logic [CNT_W-1:0] count;
    logic             last;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic       fixed;
    logic [3:0] nib;
  } cw_dec_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DATA,
    BK_STAT
  } back_state_t;

  function automatic logic [7:0] codeword(input logic [3:0] k);
    logic [7:0] c;
    unique case (k)
      4'h0: c = 8'h00;
      4'h1: c = 8'h87;
      4'h2: c = 8'h99;
      4'h3: c = 8'h1E;
      4'h4: c = 8'hAA;
      4'h5: c = 8'h2D;
      4'h6: c = 8'h33;
      4'h7: c = 8'hB4;
      4'h8: c = 8'h4B;
      4'h9: c = 8'hCC;
      4'hA: c = 8'hD2;
      4'hB: c = 8'h55;
      4'hC: c = 8'hE1;
      4'hD: c = 8'h66;
      4'hE: c = 8'h78;
      default: c = 8'hFF;
    endcase
    return c;
  endfunction

  // codeword j takes bit 7-j of each symbol, symbol i as bit i
  function automatic logic [7:0] cw_bits(input logic [7:0][7:0] syms, input logic [2:0] j);
    logic [7:0] cw;
    logic [2:0] sel;
    sel = 3'd7 - j;
    for (int i = 0; i < 8; i++) begin
      cw[i] = syms[i][sel];
    end
    return cw;
  endfunction

  function automatic cw_dec_t decode_cw(input logic [7:0] c);
    cw_dec_t    d;
    logic [3:0] s;
    logic [7:0] cf;
    logic [2:0] fb;
    logic       found;
    s  = {^c, ^(c & 8'h78), ^(c & 8'h66), ^(c & 8'h55)};
    cf = c;
    fb = 3'(s - SYN_FIRST_DATA);
    d.ok    = 1'b1;
    d.fixed = (s != 4'h0);
    d.nib   = 4'h0;
    if (s == SYN_PARITY_ONLY) begin
      cf[7] = ~cf[7];
    end else if (s >= SYN_FIRST_DATA) begin
      cf[fb] = ~cf[fb];
    end else if (s != 4'h0) begin
      d.ok = 1'b0;
    end
    found = 1'b0;
    for (int k = 0; k < 16; k++) begin
      if (codeword(4'(k)) == cf) begin
        found = 1'b1;
        d.nib = 4'(k);
      end
    end
    d.ok = d.ok & found;
    return d;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

@@ rtl/core/nrzdh_front.sv @@
module nrzdh_front import nrzdh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       frame_start,
  input  logic [7:0] raw_byte,
  input  logic       q_full,
  output logic       q_push,
  output blk_t       q_entry
);

  logic [3:0]       pos;
  logic [IDX_W-1:0] idx;
  logic             done;
  logic [7:0]       sym;
  logic [2:0]       slot;
  logic [7:0]       symbuf [0:6];
  logic             fresh;

  logic [3:0]       pos_next;
  logic [IDX_W-1:0] idx_next;
  logic             done_next;
  logic [7:0]       sym_next;
  logic [2:0]       slot_next;
  logic [7:0]       buf_next [0:6];
  logic             blk_hit;
  logic             stat_hit;
  logic [7:0]       last_sym;
  logic             in_payload;
  logic             fresh_eff;
  logic             accept;

  assign accept    = push && !q_full;
  assign fresh_eff = frame_start || fresh;

  // walk the eight line bits of the byte, msb first
  always_comb begin
    pos_next  = frame_start ? 4'd0 : pos;
    idx_next  = frame_start ? '0 : idx;
    done_next = frame_start ? 1'b0 : done;
    sym_next  = frame_start ? 8'd0 : sym;
    slot_next = frame_start ? 3'd0 : slot;
    for (int i = 0; i < 7; i++) begin
      buf_next[i] = symbuf[i];
    end
    blk_hit    = 1'b0;
    stat_hit   = 1'b0;
    last_sym   = 8'd0;
    in_payload = 1'b0;
    for (int b = 7; b >= 0; b--) begin
      if (!done_next) begin
        in_payload = !TOO_SHORT && (idx_next >= OFF_IDX) && (idx_next < END_IDX);
        if (in_payload && pos_next >= POS_MSB && pos_next <= POS_LSB) begin
          sym_next = {((pos_next == POS_MSB) ? 7'd0 : sym_next[6:0]), raw_byte[b]};
          if (pos_next == POS_LSB) begin
            if (slot_next == 3'd7) begin
              blk_hit  = 1'b1;
              last_sym = sym_next;
            end else begin
              buf_next[slot_next] = sym_next;
            end
            slot_next = slot_next + 3'd1;
          end
        end
        if (pos_next == POS_LAST) begin
          pos_next = 4'd0;
          if (idx_next == LAST_IDX) begin
            done_next = 1'b1;
            stat_hit  = 1'b1;
          end else begin
            idx_next = idx_next + IDX_W'(1);
          end
        end else begin
          pos_next = pos_next + 4'd1;
        end
      end
    end
  end

  always_comb begin
    q_push             = accept && (blk_hit || stat_hit);
    q_entry.fresh      = fresh_eff;
    q_entry.has_block  = blk_hit;
    q_entry.has_status = stat_hit;
    for (int i = 0; i < 7; i++) begin
      q_entry.syms[i] = buf_next[i];
    end
    q_entry.syms[7] = last_sym;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= 4'd0;
      idx   <= '0;
      done  <= 1'b0;
      slot  <= 3'd0;
      fresh <= 1'b1;
    end else if (accept) begin
      pos   <= pos_next;
      idx   <= idx_next;
      done  <= done_next;
      slot  <= slot_next;
      fresh <= fresh_eff && !q_push;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sym <= sym_next;
      for (int i = 0; i < 7; i++) begin
        symbuf[i] <= buf_next[i];
      end
    end
  end

endmodule

@@ rtl/core/nrzdh_blk_queue.sv @@
module nrzdh_blk_queue import nrzdh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  blk_t wr_entry,
  output logic full,
  input  logic pop,
  output logic empty,
  output blk_t rd_entry
);

  blk_t                slots [BQ_DEPTH];
  logic [BQ_PTR_W-1:0] wr_ptr;
  logic [BQ_PTR_W-1:0] rd_ptr;
  logic [BQ_PTR_W:0]   count;
  logic                push_ok;
  logic                pop_ok;

  assign full     = (count == (BQ_PTR_W + 1)'(BQ_DEPTH));
  assign empty    = (count == '0);
  assign push_ok  = push && !full;
  assign pop_ok   = pop && !empty;
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + BQ_PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + BQ_PTR_W'(1);
      end
      count <= count + (BQ_PTR_W + 1)'(push_ok) - (BQ_PTR_W + 1)'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule

@@ rtl/core/nrzdh_back.sv @@
module nrzdh_back import nrzdh_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    entry_valid,
  input  blk_t    entry,
  output logic    entry_pop,
  input  logic    pop,
  output logic    empty,
  output result_t res
);

  back_state_t      state;
  back_state_t      state_next;
  blk_t             cur;
  logic [1:0]       pair;
  logic [1:0]       pair_next;
  logic             failed;
  logic             failed_next;
  logic [CNT_W-1:0] corr;
  logic [CNT_W-1:0] corr_next;

  result_t             oq [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr;
  logic [OQ_PTR_W-1:0] rd_ptr;
  logic [OQ_PTR_W:0]   oq_count;
  logic                oq_push;
  result_t             oq_in;
  logic                room;
  logic                pop_ok;

  cw_dec_t          d0;
  cw_dec_t          d1;
  logic [CNT_W-1:0] corr_a;
  logic [CNT_W-1:0] corr_b;
  logic             pair_end;
  back_state_t      after_block;

  assign room   = (oq_count != (OQ_PTR_W + 1)'(OQ_DEPTH));
  assign empty  = (oq_count == '0);
  assign pop_ok = pop && !empty;
  assign res    = oq[rd_ptr];

  // two codewords per cycle make one byte, while the result queue has room
  always_comb begin
    d0          = decode_cw(cw_bits(cur.syms, {pair, 1'b0}));
    d1          = decode_cw(cw_bits(cur.syms, {pair, 1'b1}));
    corr_a      = d0.fixed ? sat_inc(corr) : corr;
    corr_b      = d1.fixed ? sat_inc(corr_a) : corr_a;
    pair_end    = !d0.ok || !d1.ok || (pair == 2'd3);
    after_block = cur.has_status ? BK_STAT : BK_IDLE;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (entry_valid) begin
          state_next = entry.has_block ? BK_DATA : BK_STAT;
        end
      end
      BK_DATA: begin
        if (failed || (room && pair_end)) begin
          state_next = after_block;
        end
      end
      BK_STAT: begin
        if (room) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    entry_pop   = 1'b0;
    oq_push     = 1'b0;
    oq_in       = '0;
    failed_next = failed;
    corr_next   = corr;
    pair_next   = pair;
    unique case (state)
      BK_IDLE: begin
        entry_pop = entry_valid;
        if (entry_valid) begin
          pair_next = 2'd0;
          if (entry.fresh) begin
            failed_next = 1'b0;
            corr_next   = '0;
          end
        end
      end
      BK_DATA: begin
        if (!failed && room) begin
          if (!d0.ok) begin
            failed_next = 1'b1;
          end else if (!d1.ok) begin
            // high nibble decoded, byte still dropped
            failed_next = 1'b1;
            corr_next   = corr_a;
          end else begin
            corr_next  = corr_b;
            pair_next  = pair + 2'd1;
            oq_push    = 1'b1;
            oq_in.kind = KIND_DATA;
            oq_in.data = {d0.nib, d1.nib};
          end
        end
      end
      BK_STAT: begin
        if (room) begin
          oq_push     = 1'b1;
          oq_in.kind  = KIND_STATUS;
          oq_in.ok    = !failed && !TOO_SHORT;
          oq_in.count = corr;
          oq_in.last  = 1'b1;
        end
      end
      default: begin
        entry_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      pair     <= 2'd0;
      failed   <= 1'b0;
      corr     <= '0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      oq_count <= '0;
    end else begin
      state  <= state_next;
      pair   <= pair_next;
      failed <= failed_next;
      corr   <= corr_next;
      if (oq_push) begin
        wr_ptr <= wr_ptr + OQ_PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + OQ_PTR_W'(1);
      end
      oq_count <= oq_count + (OQ_PTR_W + 1)'(oq_push) - (OQ_PTR_W + 1)'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (entry_pop) begin
      cur <= entry;
    end
    if (oq_push) begin
      oq[wr_ptr] <= oq_in;
    end
  end

endmodule

@@ rtl/core/nrz_8n1_deinterleave_hamming84_decoder.sv @@
// Frame decoder for an 8N1 line code carrying block interleaved extended
// Hamming(8,4) data. Raw bytes are taken one per cycle (push while full is
// low); a byte that starts a frame carries frame_start. The front stage
// slices each byte into 10-bit symbols in the same cycle and, once eight
// payload symbols are in, hands the 8x8 block to a two-entry block queue.
// The back stage loads each block and decodes two codewords per cycle while
// the result queue has room, yielding up to four data bytes and then the
// end-of-frame status if one is due, written into a four-entry result queue read
// with pop while empty is low. A block arrives at most every ten input bytes,
// so the input runs at one byte per clock unless results are not drained.
// The final result of every frame that reaches its last symbol is a status
// item (result_kind 1, last 1) with frame_ok and corrected_count; after an
// uncorrectable codeword no more data bytes of that frame are given.
module nrz_8n1_deinterleave_hamming84_decoder import nrzdh_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             frame_start,
  input  logic [7:0]       raw_byte,
  output logic             empty,
  input  logic             pop,
  output logic             result_kind,
  output logic [7:0]       data_byte,
  output logic             frame_ok,
  output logic [CNT_W-1:0] corrected_count,
  output logic             last
);

  logic    q_full;
  logic    q_push;
  blk_t    q_wr;
  logic    q_empty;
  logic    q_pop;
  blk_t    q_rd;
  result_t res;

  assign full = q_full;

  nrzdh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .frame_start (frame_start),
    .raw_byte    (raw_byte),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_wr)
  );

  nrzdh_blk_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_wr),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .rd_entry (q_rd)
  );

  nrzdh_back u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (!q_empty),
    .entry       (q_rd),
    .entry_pop   (q_pop),
    .pop         (pop),
    .empty       (empty),
    .res         (res)
  );

  assign result_kind     = res.kind;
  assign data_byte       = res.data;
  assign frame_ok        = res.ok;
  assign corrected_count = res.count;
  assign last            = res.last;

endmodule

@@ tb/sv/nrz_8n1_deinterleave_hamming84_decoder_tb.sv @@
`timescale 1ns / 100ps

module nrz_8n1_deinterleave_hamming84_decoder_tb;
  import nrzdh_pkg::FRAME_SYMBOLS;
  import nrzdh_pkg::OFFSET_SYMBOLS;
  import nrzdh_pkg::CODED_BLOCKS;
  import nrzdh_pkg::SYMBOL_BITS;
  import nrzdh_pkg::CNT_W;
  import nrzdh_pkg::KIND_DATA;
  import nrzdh_pkg::KIND_STATUS;
  import nrzdh_pkg::result_t;

  localparam int FRAME_BITS  = FRAME_SYMBOLS * SYMBOL_BITS;
  localparam int FRAME_BYTES = (FRAME_BITS + 7) / 8;
  localparam int PAY_END     = OFFSET_SYMBOLS + 8 * CODED_BLOCKS;
  localparam bit SHORT_FRAME = PAY_END > FRAME_SYMBOLS;
  localparam logic [3:0] SYN_PARITY = 4'h8;
  localparam logic [3:0] SYN_DATA0  = 4'h9;
  localparam logic [CNT_W-1:0] FIX_MAX = '1;

  localparam logic [7:0] CW_TABLE [16] = '{
    8'h00, 8'h87, 8'h99, 8'h1E, 8'hAA, 8'h2D, 8'h33, 8'hB4,
    8'h4B, 8'hCC, 8'hD2, 8'h55, 8'hE1, 8'h66, 8'h78, 8'hFF
  };

  typedef struct packed {
    logic       fs;
    logic [7:0] rb;
    logic       drain;
  } line_item_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic             full;
  logic             frame_start = 1'b0;
  logic [7:0]       raw_byte = 8'h00;
  logic             empty;
  logic             pop = 1'b0;
  logic             result_kind;
  logic [7:0]       data_byte;
  logic             frame_ok;
  logic [CNT_W-1:0] corrected_count;
  logic             last;

  line_item_t line_bytes_q[$];
  result_t    frame_results_q[$];
  int         n_taken = 0;
  int         n_errors = 0;

  // decoder state
  int               line_bit_cnt;
  logic [7:0]       sym_buf [8];
  logic [2:0]       sym_cnt;
  logic             dec_failed;
  logic [CNT_W-1:0] fix_cnt;

  nrz_8n1_deinterleave_hamming84_decoder i_dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .frame_start     (frame_start),
    .raw_byte        (raw_byte),
    .empty           (empty),
    .pop             (pop),
    .result_kind     (result_kind),
    .data_byte       (data_byte),
    .frame_ok        (frame_ok),
    .corrected_count (corrected_count),
    .last            (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_frame();
    line_bit_cnt = 0;
    for (int i = 0; i < 8; i++) sym_buf[i] = 8'h00;
    sym_cnt    = 3'd0;
    dec_failed = 1'b0;
    fix_cnt    = '0;
  endfunction

  // -1 uncorrectable, 0 clean, 1 one bit fixed
  function automatic int correct_codeword(input logic [7:0] c, output logic [3:0] nib);
    logic [3:0] syn;
    logic [7:0] w;
    logic [2:0] fb;
    int         st;
    syn[0] = ^(c & 8'h55);
    syn[1] = ^(c & 8'h66);
    syn[2] = ^(c & 8'h78);
    syn[3] = ^c;
    w   = c;
    st  = 0;
    nib = 4'h0;
    if (syn == SYN_PARITY) begin
      w[7] = ~w[7];
      st = 1;
    end else if (syn >= SYN_DATA0) begin
      fb = 3'(syn - SYN_DATA0);
      w[fb] = ~w[fb];
      st = 1;
    end else if (syn != 4'h0) begin
      return -1;
    end
    for (int k = 0; k < 16; k++) begin
      if (CW_TABLE[k] == w) begin
        nib = 4'(k);
        return st;
      end
    end
    return -1;
  endfunction

  function automatic void decode_block();
    logic [7:0] cw;
    logic [3:0] hi;
    logic [3:0] nib;
    result_t    r;
    int         st;
    hi = 4'h0;
    for (int j = 0; j < 8; j++) begin
      if (dec_failed) break;
      for (int i = 0; i < 8; i++) cw[i] = sym_buf[i][7-j];
      st = correct_codeword(cw, nib);
      if (st < 0) begin
        dec_failed = 1'b1;
        break;
      end
      if (st > 0 && fix_cnt != FIX_MAX) fix_cnt = fix_cnt + CNT_W'(1);
      if (j % 2 == 0) begin
        hi = nib;
      end else begin
        r.kind  = KIND_DATA;
        r.data  = {hi, nib};
        r.ok    = 1'b0;
        r.count = '0;
        r.last  = 1'b0;
        frame_results_q.push_back(r);
      end
    end
  endfunction

  function automatic void decode_line_byte(input logic fs, input logic [7:0] rb);
    int      pos;
    int      idx;
    result_t r;
    if (fs) clear_frame();
    if (line_bit_cnt >= FRAME_BITS) return;
    for (int b = 7; b >= 0; b--) begin
      pos = line_bit_cnt % SYMBOL_BITS;
      idx = line_bit_cnt / SYMBOL_BITS;
      if (!SHORT_FRAME && idx >= OFFSET_SYMBOLS && idx < PAY_END && pos >= 1 && pos <= 8) begin
        sym_buf[sym_cnt] = (pos == 1) ? {7'd0, rb[b]} : {sym_buf[sym_cnt][6:0], rb[b]};
        if (pos == 8) begin
          sym_cnt = sym_cnt + 3'd1;
          if (sym_cnt == 3'd0 && !dec_failed) decode_block();
        end
      end
      line_bit_cnt++;
      if (line_bit_cnt >= FRAME_BITS) begin
        r.kind  = KIND_STATUS;
        r.data  = 8'h00;
        r.ok    = !dec_failed && !SHORT_FRAME;
        r.count = fix_cnt;
        r.last  = 1'b1;
        frame_results_q.push_back(r);
        break;
      end
    end
  endfunction

  function automatic void add_byte(input logic fs, input logic [7:0] rb, input logic drain);
    line_item_t it;
    it.fs    = fs;
    it.rb    = rb;
    it.drain = drain;
    line_bytes_q.push_back(it);
  endfunction

  function automatic int add_noise(input int n);
    for (int i = 0; i < n; i++) add_byte($urandom_range(7) == 0, 8'($urandom_range(255)), 1'b0);
    return n;
  endfunction

  // frame: 8N1 symbols with occasionally bad framing bits, interleaved codewords, optional bit errors
  function automatic int add_frame(input int n_bytes, input int flip_pct,
                                   input bit with_fail, input bit drain);
    bit         line_bits [FRAME_BITS];
    logic [7:0] cw [8];
    logic [7:0] sym;
    logic [7:0] rb;
    int         fail_at;
    int         p;
    int         q;
    int         rel;
    fail_at = with_fail ? $urandom_range(CODED_BLOCKS * 8 - 1) : -1;
    for (int j = 0; j < 8; j++) cw[j] = 8'h00;
    for (int s = 0; s < FRAME_SYMBOLS; s++) begin
      rel = s - OFFSET_SYMBOLS;
      if (s >= OFFSET_SYMBOLS && s < PAY_END) begin
        if (rel % 8 == 0) begin
          for (int j = 0; j < 8; j++) begin
            cw[j] = CW_TABLE[$urandom_range(15)];
            p = $urandom_range(7);
            if (rel + j == fail_at) begin
              q = (p + $urandom_range(1, 7)) % 8;
              cw[j][p] = ~cw[j][p];
              cw[j][q] = ~cw[j][q];
            end else if ($urandom_range(99) < flip_pct) begin
              cw[j][p] = ~cw[j][p];
            end
          end
        end
        for (int j = 0; j < 8; j++) sym[7-j] = cw[j][rel % 8];
      end else begin
        sym = 8'($urandom_range(255));
      end
      line_bits[s*SYMBOL_BITS] = ($urandom_range(19) == 0);
      for (int k = 0; k < 8; k++) line_bits[s*SYMBOL_BITS+1+k] = sym[7-k];
      line_bits[s*SYMBOL_BITS+9] = ($urandom_range(19) != 0);
    end
    for (int n = 0; n < n_bytes; n++) begin
      for (int k = 0; k < 8; k++)
        rb[7-k] = (n*8 + k < FRAME_BITS) ? line_bits[n*8+k] : 1'($urandom_range(1));
      add_byte(n == 0, rb, drain && n == 0);
    end
    return n_bytes;
  endfunction

  always @(posedge clk) begin : drive_line
    logic sent;
    logic go;
    int   ph;
    int   idle_pct;
    if (rst) begin
      push        <= 1'b0;
      frame_start <= 1'b0;
      raw_byte    <= 8'h00;
    end else begin
      sent = push && !full;
      if (sent) begin
        decode_line_byte(frame_start, raw_byte);
        void'(line_bytes_q.pop_front());
        n_taken++;
      end
      ph = (n_taken / 48) % 4;
      idle_pct = (ph == 1) ? 76 : (ph == 3) ? 16 : 0;
      go = 1'b0;
      if (line_bytes_q.size() != 0) begin
        if (push && !sent) go = 1'b1;
        else if (line_bytes_q[0].drain && frame_results_q.size() != 0) go = 1'b0;
        else go = ($urandom_range(99) >= idle_pct);
      end
      push <= go;
      if (go) begin
        frame_start <= line_bytes_q[0].fs;
        raw_byte    <= line_bytes_q[0].rb;
      end
    end
  end

  function automatic void check_field(input string name, input int got, input int want);
    if (got != want) begin
      if (n_errors < 10)
        $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    result_t want;
    int      ph;
    int      stall_pct;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (frame_results_q.size() == 0) begin
          if (n_errors < 10)
            $display("unexpected result: kind %0d data 0x%0h ok %0d count %0d last %0d",
                     result_kind, data_byte, frame_ok, corrected_count, last);
          n_errors++;
        end else begin
          want = frame_results_q.pop_front();
          check_field("result_kind", result_kind, want.kind);
          check_field("data_byte", data_byte, want.data);
          check_field("frame_ok", frame_ok, want.ok);
          check_field("corrected_count", corrected_count, want.count);
          check_field("last", last, want.last);
        end
      end
      ph = (n_taken / 48) % 4;
      stall_pct = (ph == 2) ? 76 : (ph == 3) ? 16 : 0;
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("[nrz_8n1_deinterleave_hamming84_decoder] ERROR");
    $finish;
  end

  initial begin
    int budget;
    int n;
    int len;
    clear_frame();

    // no frame start after reset, then extremes inside the offset region
    add_byte(1'b0, 8'h00, 1'b0);
    add_byte(1'b0, 8'hFF, 1'b0);
    add_byte(1'b0, 8'hAA, 1'b0);
    add_byte(1'b0, 8'h55, 1'b0);
    add_byte(1'b0, 8'h01, 1'b0);
    add_byte(1'b0, 8'h80, 1'b0);
    add_byte(1'b0, 8'h7F, 1'b0);
    add_byte(1'b0, 8'hFE, 1'b0);
    // restart mid-frame
    add_byte(1'b1, 8'hFF, 1'b0);
    add_byte(1'b0, 8'h00, 1'b0);
    add_byte(1'b0, 8'h0F, 1'b0);
    add_byte(1'b0, 8'hF0, 1'b0);
    add_byte(1'b1, 8'h00, 1'b0);
    add_byte(1'b0, 8'hFF, 1'b0);

    // full frame with corrections and a failure, then bytes past the frame end
    budget = add_frame(FRAME_BYTES, 15, 1'b1, 1'b0);
    void'(add_noise(3));
    n = 0;
    while (budget < 355) begin
      case ($urandom_range(5))
        0: budget += add_noise($urandom_range(8, 30));
        1: begin
          len = $urandom_range(20, FRAME_BYTES - 1);
          if (len > 400 - budget) len = 400 - budget;
          budget += add_frame(len, 10, 1'($urandom_range(1)), n == 0);
        end
        default: begin
          if (budget + FRAME_BYTES <= 400)
            budget += add_frame(FRAME_BYTES, $urandom_range(20), $urandom_range(2) == 0, n == 0);
          else
            budget += add_frame($urandom_range(20, 400 - budget), $urandom_range(20), 1'b0,
                                n == 0);
        end
      endcase
      n++;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (line_bytes_q.size() != 0) @(posedge clk);
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (n_errors == 0 && frame_results_q.size() == 0) begin
      $display("[nrz_8n1_deinterleave_hamming84_decoder] OK");
    end else begin
      $display("[nrz_8n1_deinterleave_hamming84_decoder] ERROR");
    end
    $finish;
  end

endmodule
